// ===== design/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

  localparam int VALUE_W  = 32;
  localparam int CHAR_W   = 8;
  localparam int DIGITS   = 10;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIG_IDX_W = $clog2(DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SKIP,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic shift_done;
    logic negative;
    logic digit_zero;
    logic first_digit;
  } status_t;

endpackage

`default_nettype wire

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
// Sequence: load, 32 BCD shift steps, the minus sign when negative, then a skip step for
// each leading zero and the digits, most significant first. busy is low on the strobe of
// the last character, so the next start can be taken on that strobe.
// Reset (rst, synchronous) returns the controller to idle and clears strobe; no result stalls.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire signed [sida_pkg::VALUE_W-1:0] value,
  output logic [sida_pkg::CHAR_W-1:0]        character,
  output logic                               last,
  output logic                               strobe
);

  sida_pkg::cmd_t    cmd;
  sida_pkg::status_t status;

  sida_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sida_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

`default_nettype wire

// ===== design/sida_ctrl.sv =====
// Controller state machine: sequences conversion, sign, zero skip and digit output.
`timescale 1ns / 1ps
`default_nettype none

module sida_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire sida_pkg::status_t status,
  output sida_pkg::cmd_t         cmd,
  output logic                   busy
);

  sida_pkg::state_t state;
  sida_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sida_pkg::ST_IDLE: begin
        if (start) state_next = sida_pkg::ST_CONVERT;
      end
      sida_pkg::ST_CONVERT: begin
        if (status.shift_done) begin
          state_next = status.negative ? sida_pkg::ST_SIGN : sida_pkg::ST_SKIP;
        end
      end
      sida_pkg::ST_SIGN: begin
        state_next = sida_pkg::ST_SKIP;
      end
      sida_pkg::ST_SKIP: begin
        if (!(status.digit_zero && !status.first_digit)) state_next = sida_pkg::ST_DIGITS;
      end
      sida_pkg::ST_DIGITS: begin
        if (status.first_digit) state_next = sida_pkg::ST_IDLE;
      end
      default: begin
        state_next = sida_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      sida_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sida_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      sida_pkg::ST_SIGN: begin
        cmd.emit_sign = 1'b1;
      end
      sida_pkg::ST_SKIP: begin
        // drop leading zeros, but always keep the units digit
        cmd.advance = status.digit_zero && !status.first_digit;
      end
      sida_pkg::ST_DIGITS: begin
        cmd.emit_digit = 1'b1;
        cmd.advance    = !status.first_digit;
      end
      default: begin
        cmd  = '0;
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sida_datapath.sv =====
// Datapath: magnitude, shift-and-add-3 BCD conversion and character output register.
`timescale 1ns / 1ps
`default_nettype none

module sida_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  wire signed [sida_pkg::VALUE_W-1:0] value,
  input  wire sida_pkg::cmd_t                cmd,
  output sida_pkg::status_t                  status,
  output logic [sida_pkg::CHAR_W-1:0]        character,
  output logic                               last,
  output logic                               strobe
);

  logic [sida_pkg::VALUE_W-1:0]   mag;
  logic [sida_pkg::BCD_W-1:0]     bcd;
  logic [sida_pkg::BCD_W-1:0]     bcd_adj;
  logic [sida_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [sida_pkg::DIG_IDX_W-1:0] dig_idx;
  logic                           neg;
  logic [3:0]                     digit;
  logic [sida_pkg::VALUE_W-1:0]   value_u;

  assign value_u = value;

  // add 3 to every nibble of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sida_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      else                       bcd_adj[4*i +: 4] = bcd[4*i +: 4];
    end
  end

  assign digit = bcd[{dig_idx, 2'b00} +: 4];

  assign status.shift_done  = (bit_cnt == sida_pkg::BIT_CNT_W'(sida_pkg::VALUE_W - 1));
  assign status.negative    = neg;
  assign status.digit_zero  = (digit == 4'd0);
  assign status.first_digit = (dig_idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= value_u[sida_pkg::VALUE_W-1];
      // two's-complement negate stays exact for the most negative value as unsigned
      mag     <= value_u[sida_pkg::VALUE_W-1] ? (~value_u + 1'b1) : value_u;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_idx <= sida_pkg::DIG_IDX_W'(sida_pkg::DIGITS - 1);
    end else begin
      if (cmd.shift) begin
        bcd     <= {bcd_adj[sida_pkg::BCD_W-2:0], mag[sida_pkg::VALUE_W-1]};
        mag     <= {mag[sida_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
      if (cmd.advance) dig_idx <= dig_idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    character <= cmd.emit_sign ? sida_pkg::ASCII_MINUS
                               : (sida_pkg::ASCII_ZERO + {4'b0000, digit});
    last      <= cmd.emit_digit && status.first_digit;
  end

endmodule

`default_nettype wire

// ===== tb/sv/signed_int_to_decimal_ascii_test.sv =====
// Testbench for the signed integer to decimal ASCII converter, with scoreboard and driver.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int          RANDOM_CNT  = 88;
  localparam int          CALM_CNT    = 25;

  // Holds the expected text of every accepted value, oldest character first.
  class decimal_text_board;
    logic [sida_pkg::CHAR_W-1:0] char_q[$];
    logic                        last_q[$];
    int unsigned                 mismatches;
    int unsigned                 chars_checked;
    int unsigned                 values_noted;
    int unsigned                 negatives;

    function void note_value(logic [sida_pkg::VALUE_W-1:0] raw);
      logic [sida_pkg::VALUE_W-1:0] mag;
      logic [3:0]                   digits[sida_pkg::DIGITS];
      int                           ndig;
      mag = raw[sida_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
      ndig = 0;
      values_noted++;
      // Peel off digits least significant first; the most negative value needs no care.
      do begin
        digits[ndig] = 4'(mag % RADIX);
        mag = mag / RADIX;
        ndig++;
      end while (mag != 0 && ndig < sida_pkg::DIGITS);
      if (raw[sida_pkg::VALUE_W-1]) begin
        negatives++;
        char_q.push_back(sida_pkg::ASCII_MINUS);
        last_q.push_back(1'b0);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
        char_q.push_back(sida_pkg::ASCII_ZERO + {4'b0000, digits[k]});
        last_q.push_back(k == 0);
      end
    endfunction

    function void check_char(logic [sida_pkg::CHAR_W-1:0] chr, logic fin);
      logic [sida_pkg::CHAR_W-1:0] exp_chr;
      logic                        exp_fin;
      if (char_q.size() == 0) begin
        $error("unexpected character %0d (last %0d) with nothing pending", chr, fin);
        mismatches++;
        return;
      end
      exp_chr = char_q.pop_front();
      exp_fin = last_q.pop_front();
      chars_checked++;
      if (chr !== exp_chr) begin
        $error("character: expected %0d, actual %0d", exp_chr, chr);
        mismatches++;
      end
      if (fin !== exp_fin) begin
        $error("last: expected %0d, actual %0d", exp_fin, fin);
        mismatches++;
      end
    endfunction

    function int pending();
      return char_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [sida_pkg::VALUE_W-1:0]  value;
  logic [sida_pkg::CHAR_W-1:0]   character;
  logic                          last;
  logic                          strobe;

  decimal_text_board   board;
  int unsigned         cycle_count;
  int unsigned         pow10[10];

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Watch both sides of the block at every edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) board.check_char(character, last);
      if (start && !busy) board.note_value(value);
    end
  end

  function automatic logic [sida_pkg::VALUE_W-1:0] apply_sign(
    logic [sida_pkg::VALUE_W-1:0] mag);
    return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [sida_pkg::VALUE_W-1:0] pick_value();
    int unsigned k;
    k = $urandom_range(1, 9);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return apply_sign($urandom_range(0, 99));
      2: return apply_sign($urandom % pow10[k]);
      3: return apply_sign(pow10[k] - $urandom_range(0, 1));
      default: begin
        if ($urandom_range(0, 1)) return 32'h7FFF_FFFF - $urandom_range(0, 20);
        return 32'h8000_0000 + $urandom_range(0, 20);
      end
    endcase
  endfunction

  // Offer one transaction, optionally after an idle burst, and hold until accepted.
  task automatic send_value(logic [sida_pkg::VALUE_W-1:0] val, bit idle_ok);
    if (idle_ok && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      // Sometimes let the block drain so the burst falls on an idle block.
      if ($urandom_range(0, 1)) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat ($urandom_range(1, 13)) begin
        value <= $urandom;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  logic [sida_pkg::VALUE_W-1:0] directed[$];

  initial begin
    board = new();
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    pow10[0] = 1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * RADIX;
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd7, 32'd1000000, -32'sd100};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i], 1'b1);
    // Hold off until the block has emitted everything so far.
    drain_results();

    for (int i = 0; i < RANDOM_CNT; i++)
      send_value(pick_value(), i < RANDOM_CNT - CALM_CNT);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d values (%0d negative) and checked %0d characters.",
             board.values_noted, board.negatives, board.chars_checked);
    $display("Covered zero, both extremes, all digit lengths and idle bursts on both sides.");
    if (board.pending() != 0) begin
      $error("%0d expected characters never arrived", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
